@@ rtl/batch_norm_inference_assert.svh @@
// Assertion macros for the batch normalization block.
`ifndef BATCH_NORM_INFERENCE_ASSERT_SVH
`define BATCH_NORM_INFERENCE_ASSERT_SVH
`ifndef SYNTH
`define BN_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BN_ASSERT_R(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BN_ASSERT(label, clk, rst, prop, msg)
`define BN_ASSERT_R(label, clk, prop, msg)
`endif
`endif

@@ rtl/bn_pkg.sv @@
// ----------------------------------------------------------------------------
// Batch normalization package
// Shared constants and types for the batch normalization block.
// ----------------------------------------------------------------------------
`default_nettype none
package bn_pkg;
  localparam int MAX_CHANNELS_DEF = 512;
  localparam int MAX_PLANE_DEF = 4096;
  localparam logic [32:0] EPS_Q20 = 33'd10;
  localparam logic [9:0] CHANNELS_RESET = 10'd384;
  localparam logic [12:0] PLANE_RESET = 13'd196;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DATA = 1'b1;
  localparam logic [0:0] REG_CHANNELS = 1'b0;
  localparam logic [0:0] REG_PLANE = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SQRT  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_SHIFT = 6'b001000,
    ST_DATA  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;
endpackage
`default_nettype wire

@@ rtl/batch_norm_inference.sv @@
// A data request's table read and multiply are registered, then its rounded and
// saturated result is registered for output; a new data request is taken only once
// the last result is taken. A load request for a channel below MAX_CHANNELS keeps the
// block busy through 27 root steps, a divide setup, 45 divide steps, the scale and
// mean products and a table write. Reset (rst, synchronous) clears position counters,
// m_tvalid and control state, presets the sizes; scale and shift tables are not cleared.
// ----------------------------------------------------------------------------
// Batch normalization inference
// Per-channel scale and shift tables applied to a channel-major sample stream.
// ----------------------------------------------------------------------------
`default_nettype none
module batch_norm_inference #(
  parameter int MAX_CHANNELS = bn_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_PLANE = bn_pkg::MAX_PLANE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: load_channel[8:0], mean_value[24:9], variance_value[56:25],
  // gamma_value[72:57], beta_value[88:73], sample[104:89], zero fill to 112
  input  wire logic [111:0] s_tdata,
  // tuser: req_type
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: normalized[15:0], channel_of_sample[24:16], zero fill to 32
  output logic [31:0]      m_tdata,
  // tlast: last_of_tensor
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import bn_pkg::*;
  `include "batch_norm_inference_assert.svh"

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PW = (MAX_PLANE > 1) ? $clog2(MAX_PLANE) : 1;

  state_t state;
  logic [9:0]  channels_in_use;
  logic [12:0] plane_size;
  logic [PW-1:0] plane_position;
  logic [8:0]  current_channel;

  logic signed [31:0] scale_mem [MAX_CHANNELS];
  logic signed [31:0] shift_mem [MAX_CHANNELS];
  logic signed [31:0] scale_rd, shift_rd;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic signed [31:0] scale_wd, shift_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      scale_mem[mem_wa] <= scale_wd;
      shift_mem[mem_wa] <= shift_wd;
    end
    scale_rd <= scale_mem[mem_ra];
    shift_rd <= shift_mem[mem_ra];
  end

  // Load datapath registers.
  logic [8:0]  ld_ch;
  logic signed [15:0] ld_mean, ld_gamma, ld_beta;
  logic [5:0]  cnt;
  logic [53:0] sq_rem;
  logic [53:0] sq_val;
  logic [26:0] sq_res;
  logic [44:0] dv_num;
  logic [27:0] dv_rem;
  logic [44:0] dv_q;
  logic signed [31:0] scale_r;
  logic signed [47:0] prod_r;
  logic signed [15:0] smp;

  logic [15:0] gmag;
  assign gmag = ld_gamma[15] ? 16'(-ld_gamma) : ld_gamma;

  // Square root step: two radicand bits per cycle.
  logic [55:0] sq_trial;
  logic [55:0] sq_cur;
  assign sq_cur = {sq_rem, sq_val[53:52]};
  assign sq_trial = sq_cur - {27'd0, sq_res, 2'b01};

  // Divide step: one quotient bit per cycle.
  logic [28:0] dv_cur;
  logic [28:0] dv_sub;
  assign dv_cur = {dv_rem, dv_num[44]};
  assign dv_sub = dv_cur - {2'b0, sq_res};

  logic signed [45:0] q_signed;
  assign q_signed = ld_gamma[15] ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});

  logic signed [48:0] sh_acc;
  logic signed [48:0] sh_abs;
  logic [48:0] sh_mag;
  logic signed [48:0] sh_val;
  always_comb begin
    sh_acc = ($signed({{17{ld_beta[15]}}, ld_beta, 16'd0})) - 49'(prod_r);
    sh_abs = sh_acc[48] ? -sh_acc : sh_acc;
    sh_mag = (49'(sh_abs) + 49'd128) >> 8;
    sh_val = sh_acc[48] ? -$signed(sh_mag) : $signed(sh_mag);
  end

  // Data path.
  logic signed [48:0] d_acc;
  logic signed [48:0] d_abs;
  logic [48:0] d_mag;
  logic signed [48:0] d_val;
  logic [8:0] d_ch;
  logic d_last;
  logic [15:0] y_out;
  always_comb begin
    d_acc = 49'(prod_r) + $signed({{9{shift_rd[31]}}, shift_rd, 8'd0});
    d_abs = d_acc[48] ? -d_acc : d_acc;
    d_mag = (49'(d_abs) + 49'h8000) >> 16;
    d_val = d_acc[48] ? -$signed(d_mag) : $signed(d_mag);
    if (d_val > 49'sd32767) y_out = 16'h7FFF;
    else if (d_val < -49'sd32768) y_out = 16'h8000;
    else y_out = d_val[15:0];
  end

  logic [12:0] npl;
  logic [9:0]  nch;
  logic plane_end, tensor_end;
  always_comb begin
    npl = (plane_size == 13'd0) ? 13'd1 :
          (32'(plane_size) > MAX_PLANE) ? 13'(MAX_PLANE) : plane_size;
    nch = (channels_in_use == 10'd0) ? 10'd1 :
          (32'(channels_in_use) > MAX_CHANNELS) ? 10'(MAX_CHANNELS) : channels_in_use;
    plane_end = (14'(plane_position) + 14'd1) >= 14'(npl);
    tensor_end = plane_end && ((10'(current_channel) + 10'd1) >= nch);
  end

  // Output register is loaded on the cycle after the multiply.
  logic out_load;

  assign s_tready = (state == ST_IDLE) || (state == ST_OUT && m_tvalid && m_tready);
  logic take;
  assign take = s_tvalid && s_tready;

  always_comb begin
    mem_we = (state == ST_SHIFT);
    mem_wa = AW'(ld_ch);
    scale_wd = scale_r;
    shift_wd = (sh_val > 49'sh7FFFFFFF) ? 32'sh7FFFFFFF :
               (sh_val < -49'sh80000000) ? 32'sh80000000 : sh_val[31:0];
    mem_ra = (32'(current_channel) >= MAX_CHANNELS) ? AW'(0) : AW'(current_channel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      channels_in_use <= CHANNELS_RESET;
      plane_size <= PLANE_RESET;
      plane_position <= '0;
      current_channel <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CHANNELS) channels_in_use <= cfg_data[9:0];
        else plane_size <= cfg_data;
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE, ST_OUT: begin
          if (take) begin
            if (s_tuser == REQ_LOAD) begin
              if (32'(s_tdata[8:0]) < MAX_CHANNELS) begin
                state <= ST_SQRT;
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              state <= ST_DATA;
            end
          end else if (state == ST_OUT && m_tvalid && m_tready) begin
            state <= ST_IDLE;
          end
        end
        ST_SQRT: if (cnt == 6'd26) state <= ST_DIV;
        ST_DIV: if (cnt == 6'd47) state <= ST_SHIFT;
        ST_SHIFT: state <= ST_IDLE;
        ST_DATA: begin
          state <= ST_OUT;
          if (plane_end) begin
            plane_position <= '0;
            current_channel <= tensor_end ? 9'd0 : current_channel + 9'd1;
          end else begin
            plane_position <= plane_position + PW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE, ST_OUT: begin
        cnt <= '0;
        ld_ch <= s_tdata[8:0];
        ld_mean <= s_tdata[24:9];
        ld_gamma <= s_tdata[72:57];
        ld_beta <= s_tdata[88:73];
        smp <= s_tdata[104:89];
        sq_val <= {1'b0, (33'(s_tdata[56:25]) + EPS_Q20), 20'd0};
        sq_rem <= '0;
        sq_res <= '0;
      end
      ST_SQRT: begin
        cnt <= (cnt == 6'd26) ? 6'd0 : cnt + 6'd1;
        sq_val <= {sq_val[51:0], 2'b00};
        if (!sq_trial[55]) begin
          sq_rem <= sq_trial[53:0];
          sq_res <= {sq_res[25:0], 1'b1};
        end else begin
          sq_rem <= sq_cur[53:0];
          sq_res <= {sq_res[25:0], 1'b0};
        end
        dv_num <= {1'b0, 16'(0), 28'd0};
        dv_rem <= '0;
        dv_q <= '0;
      end
      ST_DIV: begin
        if (cnt == 6'd0 && dv_q == '0 && dv_rem == '0) begin
          dv_num <= (45'(gmag) << 28) + 45'(sq_res >> 1);
          cnt <= 6'd1;
        end else begin
          cnt <= cnt + 6'd1;
          if (cnt <= 6'd45) begin
            dv_num <= {dv_num[43:0], 1'b0};
            if (!dv_sub[28]) begin
              dv_rem <= dv_sub[27:0];
              dv_q <= {dv_q[43:0], 1'b1};
            end else begin
              dv_rem <= dv_cur[27:0];
              dv_q <= {dv_q[43:0], 1'b0};
            end
          end
        end
        scale_r <= (q_signed > 46'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                   (q_signed < -46'sh80000000) ? 32'sh80000000 : q_signed[31:0];
        prod_r <= 48'(ld_mean) * 48'(scale_r);
      end
      ST_SHIFT: ;
      ST_DATA: ;
      default: ;
    endcase
    if (state == ST_DATA) begin
      prod_r <= 48'(smp) * 48'(scale_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_load <= 1'b0;
    else out_load <= (state == ST_DATA);
    if (state == ST_DATA) begin
      d_ch <= 9'(mem_ra);
      d_last <= tensor_end;
    end
    if (out_load) begin
      m_tdata <= {7'd0, d_ch, y_out};
      m_tlast <= d_last;
    end
  end

  `BN_ASSERT(a_no_take_busy, clk, rst, (state == ST_SQRT) |-> !s_tready, "ready while busy")
  `BN_ASSERT(a_out_after_data, clk, rst, (state == ST_DATA) |=> ##1 m_tvalid, "no result")
  `BN_ASSERT(a_write_once, clk, rst, mem_we |=> !mem_we, "double table write")
  `BN_ASSERT_R(a_reset, clk, $past(rst) |-> !m_tvalid, "valid after reset")
endmodule
`default_nettype wire

@@ verif/batch_norm_inference_tb.sv @@
// ----------------------------------------------------------------------------
// Batch normalization inference testbench
// Drives load and sample requests with random gaps and stalls, predicts each
// normalized sample in fixed point, and compares results field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module batch_norm_inference_tb;
  import bn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LOAD_SETTLE = 80;

  typedef struct packed {
    logic [15:0] norm;
    logic [8:0]  chan;
    logic        last;
  } norm_result_t;

  typedef struct {
    logic        kind;
    logic [8:0]  chan;
    logic [15:0] mean;
    logic [31:0] var_q20;
    logic [15:0] gamma;
    logic [15:0] beta;
    logic [15:0] smp;
    bit          typed;
    logic [15:0] typed_norm;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;
  logic         m_tlast;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [12:0]  cfg_data;

  batch_norm_inference uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  longint      scale_q16 [MAX_CHANNELS_DEF];
  longint      shift_q16 [MAX_CHANNELS_DEF];
  bit          chan_loaded [MAX_CHANNELS_DEF];
  logic [9:0]  chan_count;
  logic [12:0] plane_len;
  logic [11:0] plane_pos;
  logic [8:0]  cur_chan;

  norm_result_t norm_q[$];
  int   fail_count;
  int   loads_sent;
  int   samples_sent;
  int   results_seen;
  int   hold_cycles;
  bit   quiet;
  bit   rst_done;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_nearest(longint v, int n);
    longint half;
    half = longint'(1) << (n - 1);
    if (v < 0) return -((-v + half) >>> n);
    return (v + half) >>> n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic load_coefficients(logic [8:0] ch, logic [15:0] mean, logic [31:0] var_q20,
                                   logic [15:0] gamma, logic [15:0] beta);
    longint unsigned root;
    longint unsigned mag;
    longint g;
    longint sc;
    g = longint'($signed(gamma));
    root = int_sqrt((longint'(var_q20) + EPS_Q20) << 20);
    mag = (((g < 0) ? -g : g) << 28) + (root >> 1);
    mag = mag / root;
    sc = (g < 0) ? -longint'(mag) : longint'(mag);
    sc = clamp(sc, -64'sd2147483648, 64'sd2147483647);
    scale_q16[ch] = sc;
    shift_q16[ch] = clamp(round_nearest(longint'($signed(beta)) * 65536
                                        - longint'($signed(mean)) * sc, 8),
                          -64'sd2147483648, 64'sd2147483647);
    chan_loaded[ch] = 1'b1;
  endtask

  function automatic norm_result_t normalize_sample(logic [15:0] smp);
    norm_result_t res;
    longint nch;
    longint npl;
    longint acc;
    bit plane_end;
    nch = clamp(longint'(chan_count), 1, MAX_CHANNELS_DEF);
    npl = clamp(longint'(plane_len), 1, MAX_PLANE_DEF);
    acc = longint'($signed(smp)) * scale_q16[cur_chan] + shift_q16[cur_chan] * 256;
    res.norm = 16'(clamp(round_nearest(acc, 16), -32768, 32767));
    res.chan = cur_chan;
    plane_end = longint'(plane_pos) + 1 >= npl;
    res.last = plane_end && (longint'(cur_chan) + 1 >= nch);
    if (plane_end) begin
      plane_pos = '0;
      cur_chan = res.last ? 9'd0 : cur_chan + 9'd1;
    end else begin
      plane_pos = plane_pos + 12'd1;
    end
    return res;
  endfunction

  task automatic send_request(stim_row_t r);
    int gap;
    norm_result_t res;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.kind;
    s_tdata <= {7'b0, r.smp, r.beta, r.gamma, r.var_q20, r.mean, r.chan};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (r.kind == REQ_LOAD) begin
      load_coefficients(r.chan, r.mean, r.var_q20, r.gamma, r.beta);
      loads_sent++;
    end else begin
      res = normalize_sample(r.smp);
      if (r.typed) res.norm = r.typed_norm;
      norm_q.push_back(res);
      samples_sent++;
    end
  endtask

  function automatic stim_row_t random_load(logic [8:0] ch);
    stim_row_t r;
    r.kind = REQ_LOAD;
    r.chan = ch;
    r.mean = 16'($urandom);
    r.beta = 16'($urandom);
    r.smp = 16'($urandom);
    r.typed = 1'b0;
    r.typed_norm = '0;
    case ($urandom_range(0, 3))
      0: r.var_q20 = $urandom_range(0, 64);
      1: r.var_q20 = $urandom;
      2: r.var_q20 = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: r.var_q20 = $urandom_range(32'h0001_0000, 32'h0400_0000);
    endcase
    r.gamma = $urandom_range(0, 1) ? 16'($urandom) : 16'($signed($urandom_range(0, 1023)) - 512);
    return r;
  endfunction

  function automatic stim_row_t random_sample();
    stim_row_t r;
    r = random_load(9'($urandom));
    r.kind = REQ_DATA;
    return r;
  endfunction

  task automatic settle_and_configure(logic [0:0] idx, logic [12:0] value);
    s_tvalid <= 1'b0;
    wait (norm_q.size() == 0);
    repeat (LOAD_SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CHANNELS) chan_count = value[9:0];
    else plane_len = value;
  endtask

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin
    int stall;
    norm_result_t want;
    m_tready <= 1'b0;
    wait (rst_done);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      results_seen++;
      if (norm_q.size() == 0) begin
        $error("Unexpected result: normalized %h", m_tdata[15:0]);
        fail_count++;
      end else begin
        want = norm_q.pop_front();
        if (m_tdata[15:0] !== want.norm) begin
          $error("normalized: expected %h, got %h", want.norm, m_tdata[15:0]);
          fail_count++;
        end
        if (m_tdata[24:16] !== want.chan) begin
          $error("channel_of_sample: expected %0d, got %0d", want.chan, m_tdata[24:16]);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_tensor: expected %b, got %b", want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t directed [$];
    int phase_cfg [$][3];
    int nch;
    int ndata;
    int i;
    fail_count = 0;
    loads_sent = 0;
    samples_sent = 0;
    results_seen = 0;
    hold_cycles = 0;
    quiet = 1'b0;
    rst_done = 1'b0;
    foreach (chan_loaded[k]) begin
      chan_loaded[k] = 1'b0;
      scale_q16[k] = 0;
      shift_q16[k] = 0;
    end
    chan_count = CHANNELS_RESET;
    plane_len = PLANE_RESET;
    plane_pos = '0;
    cur_chan = '0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= REQ_LOAD;
    cfg_we <= 1'b0;
    cfg_index <= REG_CHANNELS;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    rst_done = 1'b1;

    // Directed part: reset configuration, all samples land on channel 0.
    directed = '{
      '{REQ_LOAD, 9'd0, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h0000, 1'b1, 16'h0000},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h7FFF, 1'b1, 16'h0000},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h8000, 1'b1, 16'h0000},
      '{REQ_LOAD, 9'd0, 16'h0000, 32'h0000_0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 16'h0},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h7FFF, 1'b1, 16'h7FFF},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h8000, 1'b1, 16'h8000},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h0000, 1'b1, 16'h0000},
      '{REQ_LOAD, 9'd0, 16'h7FFF, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h0000, 1'b0, 16'h0},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h7FFF, 1'b0, 16'h0},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h8000, 1'b0, 16'h0},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h0001, 1'b0, 16'h0},
      '{REQ_LOAD, 9'd0, 16'h8000, 32'h0000_0001, 16'h0100, 16'h7FFF, 16'h0000, 1'b0, 16'h0},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h0100, 1'b0, 16'h0},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'hFFFF, 1'b0, 16'h0},
      '{REQ_LOAD, 9'd511, 16'h0180, 32'h0010_0000, 16'hFF00, 16'h0040, 16'h0000, 1'b0, 16'h0},
      '{REQ_LOAD, 9'd0, 16'h0080, 32'h000F_FFF6, 16'h0100, 16'hFF80, 16'h0000, 1'b0, 16'h0},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h1234, 1'b0, 16'h0},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'hEDCC, 1'b0, 16'h0},
      '{REQ_LOAD, 9'd0, 16'hFFFF, 32'h0000_0400, 16'h8001, 16'h0001, 16'h0000, 1'b0, 16'h0},
      '{REQ_DATA, 9'd0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h00FF, 1'b0, 16'h0}
    };
    foreach (directed[k]) send_request(directed[k]);

    // Random phases: channels, plane size, number of samples.
    phase_cfg = '{'{512, 4096, 150}, '{1, 1, 150}, '{0, 0, 100}, '{1023, 8191, 60},
                  '{2, 3, 150}, '{5, 4, 200}, '{512, 1, 150}};
    repeat (6) phase_cfg.push_back('{$urandom_range(1, 8), $urandom_range(1, 8), 40});
    foreach (phase_cfg[p]) begin
      settle_and_configure(REG_CHANNELS, 13'(phase_cfg[p][0]));
      settle_and_configure(REG_PLANE, 13'(phase_cfg[p][1]));
      quiet = (p % 4) == 3;
      nch = int'(clamp(longint'(chan_count), 1, MAX_CHANNELS_DEF));
      for (i = 0; i < nch; i++)
        if (!chan_loaded[i]) send_request(random_load(9'(i)));
      ndata = phase_cfg[p][2];
      for (i = 0; i < ndata; i++) begin
        if (p == 5 && i == ndata / 2) hold_cycles = 400;
        if ($urandom_range(0, 99) < 15) begin
          send_request(random_load(9'($urandom)));
          i--;
        end else begin
          send_request(random_sample());
        end
      end
    end

    s_tvalid <= 1'b0;
    wait (norm_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("Covered %0d parameter loads and %0d samples over %0d configurations;",
             loads_sent, samples_sent, phase_cfg.size() + 1);
    $display("%0d results checked, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ batch_norm_inference.f @@
+incdir+rtl
rtl/bn_pkg.sv
rtl/batch_norm_inference.sv
verif/batch_norm_inference_tb.sv
